// ----- design/pta_pkg.sv -----
// Shared types and constants for the PWM timer and channel allocator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
package pta_pkg;

  localparam int TIMER_COUNT    = 4;
  localparam int CHANNEL_COUNT  = 8;
  localparam int MAX_TIMER_BITS = 20;

  localparam int TIDX_W  = 2;   // timer index
  localparam int CH_W    = 3;   // channel index
  localparam int CT_W    = 3;   // channel binding code, 0 unbound, t+1 bound
  localparam int FREQ_W  = 27;
  localparam int CLK_W   = 28;
  localparam int DUTY_W  = 16;
  localparam int RES_W   = 5;
  localparam int CNT_W   = 36;  // scaled duty width
  localparam int USER_W  = 8;   // user count, saturates at all ones
  localparam int SHIFT_W = 48;  // frequency shifted by up to MAX_TIMER_BITS+1
  localparam int DIVC_W  = 6;   // divider step counter
  localparam int PADDR_W = 5;

  typedef enum logic [1:0] {
    MODE_CLAIM    = 2'd0,
    MODE_SET_FREQ = 2'd1,
    MODE_SET_DUTY = 2'd2,
    MODE_RELEASE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_MASK = 3'd0,
    REG_TIMER_MASK   = 3'd1,
    REG_DEFAULT_FREQ = 3'd2,
    REG_SOURCE_CLOCK = 3'd3,
    REG_DUTY_FULL    = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAIM,
    ST_EVAL,
    ST_RES,
    ST_WRITE,
    ST_INC,
    ST_DROP,
    ST_OK,
    ST_FINAL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [CHANNEL_COUNT-1:0] channel_mask;
    logic [TIMER_COUNT-1:0]   timer_mask;
    logic [FREQ_W-1:0]        default_frequency;
    logic [CLK_W-1:0]         source_clock;
    logic [DUTY_W-1:0]        duty_full;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic claim;
    logic release_ch;
    logic drop_rel;
    logic drop_sf;
    logic write_duty;
    logic sel_match;
    logic sel_own;
    logic sel_free;
    logic fail;
    logic res_step;
    logic write_timer;
    logic inc_user;
    logic final_load;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  own_vld;
    logic  own_freq_match;
    logic  own_single;
    logic  own_saved;
    logic  match_found;
    logic  free_found;
    logic  retune;
    logic  res_stop;
    logic  bound;
    logic  div_last;
  } sts_t;

endpackage

// ----- design/pta_ctrl.sv -----
// Sequencing state machine of the allocator.
// Depends on pta_pkg; drives pta_dpath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
module pta_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pta_pkg::sts_t  sts,
  output pta_pkg::cmd_t  cmd
);
  import pta_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    out_valid  = (state == ST_OUT);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_CLAIM: begin
        cmd.claim  = 1'b1;
        state_next = ST_FINAL;
      end
      ST_EVAL: begin
        state_next = ST_FINAL;
        if (sts.mode == MODE_CLAIM) begin
          state_next = ST_CLAIM;
        end else if (sts.mode == MODE_RELEASE) begin
          cmd.drop_rel   = sts.own_vld;
          cmd.release_ch = 1'b1;
        end else if (sts.mode == MODE_SET_DUTY && sts.own_vld) begin
          cmd.write_duty = 1'b1;
        end else if (sts.own_vld && sts.own_freq_match) begin
          // Already on a timer of that frequency: nothing changes.
          state_next = ST_OK;
        end else if (sts.match_found) begin
          cmd.sel_match = 1'b1;
          state_next    = ST_INC;
        end else if (sts.own_vld && sts.own_single) begin
          cmd.sel_own = 1'b1;
          state_next  = ST_RES;
        end else if (sts.free_found) begin
          cmd.sel_free = 1'b1;
          state_next   = ST_RES;
        end else begin
          cmd.fail = 1'b1;
        end
      end
      ST_RES: begin
        if (sts.res_stop) begin
          state_next = ST_WRITE;
        end else begin
          cmd.res_step = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.write_timer = 1'b1;
        state_next      = sts.retune ? ST_OK : ST_INC;
      end
      ST_INC: begin
        cmd.inc_user = 1'b1;
        state_next   = sts.own_saved ? ST_DROP : ST_OK;
      end
      ST_DROP: begin
        cmd.drop_sf = 1'b1;
        state_next  = ST_OK;
      end
      ST_OK: begin
        cmd.write_duty = (sts.mode == MODE_SET_DUTY);
        state_next     = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.final_load = 1'b1;
        state_next     = sts.bound ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/pta_dpath.sv -----
// Datapath of the allocator: channel and timer records, timer searches,
// resolution loop, rounding divider and result registers. Depends on pta_pkg.
`timescale 1ns / 1ps
module pta_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  pta_pkg::cfg_t                  cfg,
  input  pta_pkg::cmd_t                  cmd,
  input  logic [1:0]                     in_mode,
  input  logic [pta_pkg::CH_W-1:0]       in_channel,
  input  logic [pta_pkg::FREQ_W-1:0]     in_freq,
  input  logic [pta_pkg::DUTY_W-1:0]     in_duty,
  output pta_pkg::sts_t                  sts,
  output logic                           o_status,
  output logic [pta_pkg::CH_W-1:0]       o_channel,
  output logic                           o_bound,
  output logic [pta_pkg::TIDX_W-1:0]     o_timer,
  output logic [pta_pkg::RES_W-1:0]      o_res,
  output logic [pta_pkg::CNT_W-1:0]      o_counts,
  output logic [pta_pkg::FREQ_W-1:0]     o_tfreq
);
  import pta_pkg::*;

  logic [CHANNEL_COUNT-1:0] taken;
  logic [CT_W-1:0]          ch_timer [CHANNEL_COUNT];
  logic [DUTY_W-1:0]        ch_duty  [CHANNEL_COUNT];
  logic [FREQ_W-1:0]        t_freq   [TIMER_COUNT];
  logic [RES_W-1:0]         t_bits   [TIMER_COUNT];
  logic [USER_W-1:0]        t_users  [TIMER_COUNT];

  mode_t              req_mode;
  logic [CH_W-1:0]    req_chan;
  logic [FREQ_W-1:0]  req_freq;
  logic [DUTY_W-1:0]  req_duty;
  logic [TIDX_W-1:0]  tgt, own_q;
  logic               own_q_vld, retune;
  logic [RES_W-1:0]   res_b;
  logic [SHIFT_W-1:0] res_sh;
  logic [DUTY_W-1:0]  div_d;
  logic [DUTY_W-1:0]  rem;
  logic [DIVC_W-1:0]  div_cnt;

  logic [CT_W-1:0]    own_code;
  logic               own_vld;
  logic [TIDX_W-1:0]  own_idx;
  logic               match_found, free_found, claim_found;
  logic [TIDX_W-1:0]  match_idx, free_idx;
  logic [CH_W-1:0]    claim_idx;
  logic [TIDX_W-1:0]  drop_idx;
  logic [DUTY_W:0]    trial;
  logic               ge;
  logic [DUTY_W-1:0]  full_eff;
  logic               fin_bound;
  logic [RES_W-1:0]   fin_bits;

  assign own_code = ch_timer[req_chan];
  assign own_vld  = (own_code != '0) && (own_code <= CT_W'(TIMER_COUNT));
  assign own_idx  = TIDX_W'(own_code - CT_W'(1));

  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    for (int t = TIMER_COUNT - 1; t >= 0; t--) begin
      if (cfg.timer_mask[t] && t_users[t] != '0 && t_freq[t] == req_freq) begin
        match_found = 1'b1;
        match_idx   = TIDX_W'(t);
      end
      if (cfg.timer_mask[t] && t_users[t] == '0) begin
        free_found = 1'b1;
        free_idx   = TIDX_W'(t);
      end
    end
  end

  always_comb begin
    claim_found = 1'b0;
    claim_idx   = '0;
    for (int k = CHANNEL_COUNT - 1; k >= 0; k--) begin
      if (cfg.channel_mask[k] && !taken[k]) begin
        claim_found = 1'b1;
        claim_idx   = CH_W'(k);
      end
    end
  end

  assign drop_idx  = cmd.drop_sf ? own_q : own_idx;
  assign trial     = {rem, o_counts[CNT_W-1]};
  assign ge        = trial >= {1'b0, div_d};
  assign full_eff  = (cfg.duty_full == '0) ? DUTY_W'(1) : cfg.duty_full;
  assign fin_bound = own_vld && (req_mode != MODE_CLAIM);
  assign fin_bits  = t_bits[own_idx];

  always_comb begin
    sts                = '0;
    sts.mode           = req_mode;
    sts.own_vld        = own_vld;
    sts.own_freq_match = (t_freq[own_idx] == req_freq);
    sts.own_single     = (t_users[own_idx] == USER_W'(1));
    sts.own_saved      = own_q_vld;
    sts.match_found    = match_found;
    sts.free_found     = free_found;
    sts.retune         = retune;
    sts.res_stop       = (res_b == RES_W'(MAX_TIMER_BITS)) ||
                         (res_sh > SHIFT_W'(cfg.source_clock));
    sts.bound          = fin_bound;
    sts.div_last       = (div_cnt == DIVC_W'(CNT_W - 1));
  end

  // Channel records. Binding and duty have no reset; claim writes both.
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else begin
      if (cmd.claim && claim_found) begin
        taken[claim_idx] <= 1'b1;
      end
      if (cmd.release_ch) begin
        taken[req_chan] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.claim && claim_found) begin
      ch_timer[claim_idx] <= '0;
      ch_duty[claim_idx]  <= '0;
    end
    if (cmd.release_ch) begin
      ch_timer[req_chan] <= '0;
    end
    if (cmd.inc_user) begin
      ch_timer[req_chan] <= CT_W'(tgt) + CT_W'(1);
    end
    if (cmd.write_duty) begin
      ch_duty[req_chan] <= req_duty;
    end
  end

  // Timer records. A drop saturates at zero and frees the timer there.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TIMER_COUNT; t++) begin
        t_freq[t]  <= '0;
        t_bits[t]  <= '0;
        t_users[t] <= '0;
      end
    end else begin
      for (int t = 0; t < TIMER_COUNT; t++) begin
        if (cmd.write_timer && tgt == TIDX_W'(t)) begin
          t_freq[t] <= req_freq;
          t_bits[t] <= res_b;
        end
        if (cmd.inc_user && tgt == TIDX_W'(t) && t_users[t] != '1) begin
          t_users[t] <= t_users[t] + USER_W'(1);
        end
        if ((cmd.drop_sf || cmd.drop_rel) && drop_idx == TIDX_W'(t)) begin
          if (t_users[t] != '0) begin
            t_users[t] <= t_users[t] - USER_W'(1);
          end
          if (t_users[t] <= USER_W'(1)) begin
            t_freq[t] <= '0;
          end
        end
      end
    end
  end

  // Request, search results and the iterative units.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode_t'(in_mode);
      req_chan <= in_channel;
      req_freq <= (mode_t'(in_mode) == MODE_SET_DUTY) ? cfg.default_frequency : in_freq;
      req_duty <= in_duty;
      o_status <= 1'b0;
    end
    if (cmd.claim) begin
      req_chan <= claim_idx;
      o_status <= !claim_found;
    end
    if (cmd.fail) begin
      o_status <= 1'b1;
    end
    if (cmd.sel_match || cmd.sel_own || cmd.sel_free) begin
      own_q     <= own_idx;
      own_q_vld <= own_vld;
      retune    <= cmd.sel_own;
      res_b     <= '0;
      res_sh    <= SHIFT_W'({req_freq, 1'b0});
    end
    if (cmd.sel_match) tgt <= match_idx;
    if (cmd.sel_own)   tgt <= own_idx;
    if (cmd.sel_free)  tgt <= free_idx;
    if (cmd.res_step) begin
      res_b  <= res_b + RES_W'(1);
      res_sh <= {res_sh[SHIFT_W-2:0], 1'b0};
    end
    if (cmd.final_load) begin
      o_channel <= req_chan;
      o_bound   <= fin_bound;
      o_timer   <= fin_bound ? own_idx : '0;
      o_res     <= fin_bound ? fin_bits : '0;
      o_tfreq   <= fin_bound ? t_freq[own_idx] : '0;
      o_counts  <= fin_bound ? ((CNT_W'(ch_duty[req_chan]) << fin_bits) +
                               CNT_W'(full_eff >> 1)) : '0;
      div_d     <= full_eff;
      rem       <= '0;
      div_cnt   <= '0;
    end
    if (cmd.div_step) begin
      // Restoring division: the dividend shifts out as the quotient shifts in.
      rem      <= ge ? DUTY_W'(trial - {1'b0, div_d}) : trial[DUTY_W-1:0];
      o_counts <= {o_counts[CNT_W-2:0], ge};
      div_cnt  <= div_cnt + DIVC_W'(1);
    end
  end

endmodule

// ----- design/pwm_timer_channel_allocator_unit.sv -----
// Top level of the PWM channel and timer allocator: stream ports, APB register
// file and the pta_ctrl / pta_dpath pair. Depends on pta_pkg.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  one request transaction
//  m_*       out        m_tvalid/m_tready  one result transaction per request
//  APB       in/out     psel/penable       five configuration registers
//
// One request is handled at a time; s_tready is high only while idle.
// A claim goes through the claim state, and any other unbound result goes
// straight to the output register; a bound result first runs the bit-serial
// rounding divider. A set-frequency may add timer bookkeeping and a resolution
// search before the result is formed.
// A stalled result holds in the output register until m_tready is seen.
// Reset is synchronous; the timer table and claimed bits clear at once.
module pwm_timer_channel_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[1:0], channel[4:2], frequency[31:5], duty[47:32]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[0], granted_channel[3:1], bound[4], timer_index[6:5],
  // resolution[11:7], duty_counts[47:12], timer_frequency[74:48], zero[79:75]
  output logic [79:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [pta_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pta_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  reg_idx_t reg_sel;

  logic                o_status, o_bound;
  logic [CH_W-1:0]     o_channel;
  logic [TIDX_W-1:0]   o_timer;
  logic [RES_W-1:0]    o_res;
  logic [CNT_W-1:0]    o_counts;
  logic [FREQ_W-1:0]   o_tfreq;

  // Registers sit at word addresses; the two low address bits are ignored.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_mask      <= '1;
      cfg.timer_mask        <= '1;
      cfg.default_frequency <= FREQ_W'(5000);
      cfg.source_clock      <= CLK_W'(80000000);
      cfg.duty_full         <= DUTY_W'(65535);
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_CHANNEL_MASK: cfg.channel_mask      <= pwdata[CHANNEL_COUNT-1:0];
        REG_TIMER_MASK:   cfg.timer_mask        <= pwdata[TIMER_COUNT-1:0];
        REG_DEFAULT_FREQ: cfg.default_frequency <= pwdata[FREQ_W-1:0];
        REG_SOURCE_CLOCK: cfg.source_clock      <= pwdata[CLK_W-1:0];
        REG_DUTY_FULL:    cfg.duty_full         <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CHANNEL_MASK: prdata = 32'(cfg.channel_mask);
      REG_TIMER_MASK:   prdata = 32'(cfg.timer_mask);
      REG_DEFAULT_FREQ: prdata = 32'(cfg.default_frequency);
      REG_SOURCE_CLOCK: prdata = 32'(cfg.source_clock);
      REG_DUTY_FULL:    prdata = 32'(cfg.duty_full);
      default:          prdata = '0;
    endcase
  end

  pta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pta_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .in_mode    (s_tdata[1:0]),
    .in_channel (s_tdata[4:2]),
    .in_freq    (s_tdata[31:5]),
    .in_duty    (s_tdata[47:32]),
    .sts        (sts),
    .o_status   (o_status),
    .o_channel  (o_channel),
    .o_bound    (o_bound),
    .o_timer    (o_timer),
    .o_res      (o_res),
    .o_counts   (o_counts),
    .o_tfreq    (o_tfreq)
  );

  assign m_tdata = {5'b0, o_tfreq, o_counts, o_res, o_timer, o_bound, o_channel, o_status};

  // Only one request is ever in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("request accepted while a result is pending");

  // An unbound result carries no timer, resolution, counts or frequency.
  a_unbound_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[4]) |-> (m_tdata[79:5] == '0))
    else $error("unbound result carries timer data");

  // Resolution never exceeds the timer's maximum.
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:7] <= RES_W'(MAX_TIMER_BITS)))
    else $error("resolution out of range");

  // A divider that runs to completion always leads on to a shown bound result.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && sts.div_last) |=> m_tvalid)
    else $error("divider finished without presenting a result");

endmodule

// ----- bench/pwm_timer_channel_allocator_unit_tb.sv -----
// Self-checking bench for pwm_timer_channel_allocator_unit: drives request transactions,
// predicts each result from a behavioral model of the allocator and checks it.
// Depends on pta_pkg and the design top level.
`timescale 1ns / 1ps
module pwm_timer_channel_allocator_unit_tb;
  import pta_pkg::*;

  // Worst correct run: about 1900 requests at worst-case length, doubled by
  // random input gaps and output stalls, plus the HOLD_CYCLES hold; several times over.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 100;

  typedef struct {
    bit        status;
    bit [2:0]  channel;
    bit        bound;
    bit [1:0]  timer;
    bit [4:0]  res;
    bit [35:0] counts;
    bit [26:0] freq;
  } alloc_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pwm_timer_channel_allocator_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the allocator registers and tables.
  bit [7:0]  chan_allow;
  bit [3:0]  timer_allow;
  bit [26:0] default_hz;
  bit [27:0] src_hz;
  bit [15:0] full_duty;
  bit [7:0]  claimed;
  bit [2:0]  binding [CHANNEL_COUNT];   // 0 unbound, t+1 bound to timer t
  bit [15:0] chan_duty [CHANNEL_COUNT];
  bit [26:0] tmr_hz [TIMER_COUNT];
  bit [4:0]  tmr_res [TIMER_COUNT];
  bit [7:0]  tmr_users [TIMER_COUNT];

  alloc_result_t pending_results[$];
  bit  failed;
  bit  quiet;        // when set, neither side idles
  bit  hold_req;     // asks the result side for a long hold-off
  int  hold_count;
  int  cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Largest shift such that the timer still fits under the source clock.
  function automatic bit [4:0] resolution_for(bit [26:0] hz);
    int b;
    b = 0;
    while (b < MAX_TIMER_BITS && ((longint'(hz) << (b + 1)) <= longint'(src_hz))) b++;
    return b[4:0];
  endfunction

  // Lowest allowed timer that is running at hz (busy) or has no users (free).
  function automatic int lookup_timer(bit busy, bit [26:0] hz);
    for (int t = 0; t < TIMER_COUNT; t++) begin
      if (!timer_allow[t]) continue;
      if (busy ? (tmr_users[t] != 0 && tmr_hz[t] == hz) : (tmr_users[t] == 0)) return t;
    end
    return -1;
  endfunction

  function automatic void drop_user(int t);
    if (tmr_users[t] > 0) tmr_users[t]--;
    if (tmr_users[t] == 0) tmr_hz[t] = '0;
  endfunction

  function automatic int bound_timer(int c);
    return (binding[c] == 0 || binding[c] > TIMER_COUNT) ? -1 : binding[c] - 1;
  endfunction

  // Moves a channel onto a timer at hz; returns 0 when no timer is available.
  function automatic bit retune_channel(int c, bit [26:0] hz);
    int own;
    int target;
    own = bound_timer(c);
    if (own >= 0 && tmr_hz[own] == hz) return 1'b1;
    target = lookup_timer(1'b1, hz);
    // A channel alone on its timer retunes that timer in place.
    if (target < 0 && own >= 0 && tmr_users[own] == 1) begin
      tmr_hz[own]  = hz;
      tmr_res[own] = resolution_for(hz);
      return 1'b1;
    end
    if (target < 0) begin
      target = lookup_timer(1'b0, '0);
      if (target < 0) return 1'b0;
      tmr_hz[target]  = hz;
      tmr_res[target] = resolution_for(hz);
    end
    if (tmr_users[target] != 8'hFF) tmr_users[target]++;
    binding[c] = 3'(target + 1);
    if (own >= 0) drop_user(own);
    return 1'b1;
  endfunction

  function automatic alloc_result_t predict_allocation(mode_t mode, int c, bit [26:0] hz,
                                                       bit [15:0] duty);
    alloc_result_t r;
    bit ok;
    bit [15:0] prev;
    int t;
    longint unsigned divisor;
    r = '{default: 0};
    ok = 1'b1;
    if (mode == MODE_CLAIM) begin
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
        if (!chan_allow[k] || claimed[k]) continue;
        claimed[k]   = 1'b1;
        binding[k]   = '0;
        chan_duty[k] = '0;
        r.channel    = 3'(k);
        return r;
      end
      r.status = 1'b1;
      return r;
    end
    r.channel = 3'(c);
    case (mode)
      MODE_SET_FREQ: ok = retune_channel(c, hz);
      MODE_SET_DUTY: begin
        prev = chan_duty[c];
        chan_duty[c] = duty;
        // An unbound channel is bound at the default frequency first.
        if (bound_timer(c) < 0) begin
          ok = retune_channel(c, default_hz);
          if (!ok) chan_duty[c] = prev;
        end
      end
      default: begin
        t = bound_timer(c);
        if (t >= 0) drop_user(t);
        binding[c] = '0;
        claimed[c] = 1'b0;
      end
    endcase
    r.status = !ok;
    t = bound_timer(c);
    if (t >= 0) begin
      divisor  = (full_duty == 0) ? 1 : full_duty;
      r.bound  = 1'b1;
      r.timer  = 2'(t);
      r.res    = tmr_res[t];
      r.counts = 36'(((longint'(chan_duty[c]) << tmr_res[t]) + divisor / 2) / divisor);
      r.freq   = tmr_hz[t];
    end
    return r;
  endfunction

  // Result side: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      hold_count <= 0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      m_tready   <= 1'b0;
    end else begin
      if (!hold_req) hold_count <= 0;
      m_tready <= quiet || ($urandom_range(99) >= 34);
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Each result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, m_tdata[0]);
        check_field("granted_channel", want.channel, m_tdata[3:1]);
        check_field("bound", want.bound, m_tdata[4]);
        check_field("timer_index", want.timer, m_tdata[6:5]);
        check_field("resolution", want.res, m_tdata[11:7]);
        check_field("duty_counts", want.counts, m_tdata[47:12]);
        check_field("timer_frequency", want.freq, m_tdata[74:48]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one request, waits until it is accepted and records the prediction.
  task automatic send_request(mode_t mode, int c, bit [26:0] hz, bit [15:0] duty);
    while (!quiet && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {duty, hz, c[2:0], mode};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_allocation(mode, c, hz, duty));
  endtask

  task automatic write_register(reg_idx_t idx, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CHANNEL_MASK: chan_allow  = value[7:0];
      REG_TIMER_MASK:   timer_allow = value[3:0];
      REG_DEFAULT_FREQ: default_hz  = value[26:0];
      REG_SOURCE_CLOCK: src_hz      = value[27:0];
      default:          full_duty   = value[15:0];
    endcase
  endtask

  // Lets every outstanding result arrive before registers change.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic configure(bit [7:0] cm, bit [3:0] tm, bit [26:0] dhz, bit [27:0] shz,
                           bit [15:0] full);
    drain();
    write_register(REG_CHANNEL_MASK, 32'(cm));
    write_register(REG_TIMER_MASK, 32'(tm));
    write_register(REG_DEFAULT_FREQ, 32'(dhz));
    write_register(REG_SOURCE_CLOCK, 32'(shz));
    write_register(REG_DUTY_FULL, 32'(full));
  endtask

  // Claims every channel first so that no binding or duty is read unwritten,
  // then walks the field extremes and the sharing, retune and failure paths.
  task automatic test_directed;
    for (int k = 0; k < CHANNEL_COUNT; k++) send_request(MODE_CLAIM, 0, '0, '0);
    send_request(MODE_CLAIM, 7, 27'h7FFFFFF, 16'hFFFF);     // no channel left
    send_request(MODE_SET_FREQ, 0, 27'd80000000, '0);       // fastest, no resolution
    send_request(MODE_SET_FREQ, 1, 27'd0, '0);              // zero frequency, full resolution
    send_request(MODE_SET_FREQ, 2, 27'd80000000, '0);       // joins a running timer
    send_request(MODE_SET_DUTY, 3, '0, 16'hFFFF);           // binds at the default
    send_request(MODE_SET_DUTY, 4, '0, 16'h0000);           // shares the default timer
    send_request(MODE_SET_FREQ, 1, 27'd1234, '0);           // sole user retunes in place
    send_request(MODE_SET_FREQ, 5, 27'd77, '0);             // fourth timer
    send_request(MODE_SET_FREQ, 6, 27'd99, '0);             // no timer left
    send_request(MODE_SET_DUTY, 7, '0, 16'h5A5A);           // shares the default timer
    send_request(MODE_RELEASE, 5, '0, '0);                  // frees a timer
    send_request(MODE_RELEASE, 5, '0, '0);                  // release of unbound channel
    send_request(MODE_SET_DUTY, 7, '0, 16'hA5A5);
    send_request(MODE_SET_FREQ, 2, 27'd1234, '0);           // moves, old timer keeps user
    send_request(MODE_CLAIM, 0, '0, '0);                    // regrants channel five
  endtask

  task automatic send_random_request;
    mode_t     mode;
    bit [26:0] hz;
    int        pick;
    pick = $urandom_range(99);
    mode = pick < 35 ? MODE_SET_FREQ : pick < 70 ? MODE_SET_DUTY :
           pick < 85 ? MODE_CLAIM : MODE_RELEASE;
    // Mostly a small pool of frequencies so that timers get shared.
    case ($urandom_range(9))
      0, 1:    hz = 27'd1000;
      2, 3:    hz = 27'd25000;
      4:       hz = 27'd5000;
      5:       hz = default_hz;
      6:       hz = 27'($urandom_range(80000000, 0));
      7:       hz = '0;
      8:       hz = 27'd80000000;
      default: hz = 27'($urandom_range(999, 1));
    endcase
    send_request(mode, $urandom_range(CHANNEL_COUNT - 1), hz, 16'($urandom));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < count / 2);
      send_random_request();
    end
    quiet = 1'b0;
  endtask

  // Holds the result side while requests keep coming, so the input stalls.
  task automatic test_backpressure;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_random_request();
    hold_req = 1'b0;
  endtask

  initial begin
    failed   = 1'b0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    cycles   = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    chan_allow  = 8'hFF;
    timer_allow = 4'hF;
    default_hz  = 27'd5000;
    src_hz      = 28'd80000000;
    full_duty   = 16'hFFFF;
    claimed     = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      binding[i]   = '0;
      chan_duty[i] = '0;
    end
    for (int i = 0; i < TIMER_COUNT; i++) begin
      tmr_hz[i]    = '0;
      tmr_res[i]   = '0;
      tmr_users[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(310);
    configure(8'h0F, 4'h1, 27'd1, 28'd160000000, 16'd1);
    test_random(310);
    configure(8'h00, 4'h0, 27'd80000000, 28'd1, 16'd0);
    test_random(300);
    configure(8'hF0, 4'hA, 27'd123457, 28'd40000000, 16'd1000);
    test_random(310);
    configure(8'hA5, 4'h6, 27'h4000000, 28'h8000000, 16'h8000);
    test_random(310);
    configure(8'hFF, 4'hF, 27'd5000, 28'd80000000, 16'hFFFF);
    test_random(310);

    drain();
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
